// File: rtl/fsqn_pkg.sv
// Shared constants, types and codes for the binary64 Newton square root block.
package fsqn_pkg;

    localparam int MAX_ITERATIONS = 5;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int DIV_STEPS      = 56;
    localparam int DCNT_W         = $clog2(DIV_STEPS);

    localparam logic [63:0] SEED_BIAS = 64'h1FF0_0000_0000_0000;
    localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [12:0] EXP_BIAS  = 13'd1023;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_QRND,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic norm_step;
        logic div_init;
        logic div_step;
        logic q_round;
        logic add_step;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic norm_done;
        logic same;
    } sts_t;

endpackage

// File: rtl/fsqn_ctrl.sv
// Sequencer for operand load, normalization, division steps and Newton updates.
module fsqn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  fsqn_pkg::sts_t      sts,
    output fsqn_pkg::cmd_t      cmd
);

    fsqn_pkg::state_t               state_reg, state_next;
    logic [fsqn_pkg::DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [fsqn_pkg::ITER_W-1:0]    iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsqn_pkg::ST_IDLE;
            dcnt_reg  <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            fsqn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    iter_next = '0;
                    state_next = sts.special ? fsqn_pkg::ST_DONE : fsqn_pkg::ST_NORM;
                end
            end
            fsqn_pkg::ST_NORM:
            begin
                if (sts.norm_done)
                begin
                    cmd.div_init = 1'b1;
                    dcnt_next    = '0;
                    state_next   = fsqn_pkg::ST_DIV;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            fsqn_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == fsqn_pkg::DCNT_W'(fsqn_pkg::DIV_STEPS - 1))
                    state_next = fsqn_pkg::ST_QRND;
            end
            fsqn_pkg::ST_QRND:
            begin
                cmd.q_round = 1'b1;
                state_next  = fsqn_pkg::ST_ADD;
            end
            fsqn_pkg::ST_ADD:
            begin
                cmd.add_step = 1'b1;
                // stop once the estimate settles or the step budget is spent
                if (sts.same ||
                    iter_reg == fsqn_pkg::ITER_W'(fsqn_pkg::MAX_ITERATIONS - 1))
                begin
                    state_next = fsqn_pkg::ST_DONE;
                end
                else
                begin
                    iter_next    = iter_reg + 1'b1;
                    cmd.div_init = 1'b1;
                    dcnt_next    = '0;
                    state_next   = fsqn_pkg::ST_DIV;
                end
            end
            fsqn_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = fsqn_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsqn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/fsqn_dp.sv
// Datapath: operand unpack, radix-2 restoring divider, rounding adder and halving.
module fsqn_dp (
    input  logic            clk,
    input  logic [63:0]     operand_bits,
    input  fsqn_pkg::cmd_t  cmd,
    output fsqn_pkg::sts_t  sts,
    output logic [63:0]     root_bits
);

    logic [52:0]        x_man_reg;
    logic signed [12:0] x_exp_reg;
    logic [63:0]        g_reg;
    logic [53:0]        rem_reg;
    logic [55:0]        quo_reg;
    logic [51:0]        q_frac_reg;
    logic [10:0]        q_exp_reg;

    // operand classification
    logic        in_exp_max, in_exp_zero, in_frac_nz, in_special;
    logic [63:0] in_special_val;

    always_comb
    begin
        in_exp_max  = &operand_bits[62:52];
        in_exp_zero = ~|operand_bits[62:52];
        in_frac_nz  = |operand_bits[51:0];
        in_special  = 1'b1;
        in_special_val = operand_bits;
        if (in_exp_max && in_frac_nz)
            in_special_val = operand_bits;
        else if (operand_bits[62:0] == 63'd0)
            in_special_val = operand_bits;
        else if (operand_bits[63])
            in_special_val = fsqn_pkg::QUIET_NAN;
        else if (operand_bits == fsqn_pkg::POS_INF)
            in_special_val = operand_bits;
        else
            in_special = 1'b0;
    end

    // divider step
    logic [52:0] g_man;
    logic        rem_ge;
    logic [53:0] rem_diff;

    always_comb
    begin
        g_man    = {1'b1, g_reg[51:0]};
        rem_ge   = rem_reg >= {1'b0, g_man};
        rem_diff = rem_ge ? (rem_reg - {1'b0, g_man}) : rem_reg;
    end

    // quotient rounding
    logic               q_top, q_grd, q_stk, q_inc;
    logic [52:0]        q_pre;
    logic [53:0]        q_sum;
    logic signed [12:0] q_exp_raw;
    logic [51:0]        q_frac_next;
    logic [10:0]        q_exp_next;

    always_comb
    begin
        q_top = quo_reg[55];
        q_pre = q_top ? quo_reg[55:3] : quo_reg[54:2];
        q_grd = q_top ? quo_reg[2] : quo_reg[1];
        q_stk = (q_top ? (|quo_reg[1:0]) : quo_reg[0]) | (|rem_reg);
        q_inc = q_grd & (q_stk | q_pre[0]);
        q_sum = {1'b0, q_pre} + 54'(q_inc);
        q_exp_raw = x_exp_reg - $signed({2'b00, g_reg[62:52]})
                  + $signed(fsqn_pkg::EXP_BIAS) - (q_top ? 13'sd0 : 13'sd1);
        if (q_sum[53])
        begin
            q_frac_next = q_sum[52:1];
            q_exp_next  = q_exp_raw[10:0] + 11'd1;
        end
        else
        begin
            q_frac_next = q_sum[51:0];
            q_exp_next  = q_exp_raw[10:0];
        end
    end

    // g + q, rounded, then halved (exact: values stay normal)
    logic        g_big, a_stk, a_grd, a_inc;
    logic [10:0] big_exp, small_exp, a_diff;
    logic [51:0] big_frac, small_frac;
    logic [5:0]  a_sh;
    logic [55:0] small_ext, small_shf;
    logic [56:0] a_sum;
    logic [55:0] a_norm;
    logic [11:0] a_exp;
    logic [53:0] a_rnd;
    logic [51:0] ng_frac;
    logic [11:0] ng_exp;
    logic [63:0] ng_bits;

    always_comb
    begin
        g_big      = g_reg[62:52] >= q_exp_reg;
        big_exp    = g_big ? g_reg[62:52] : q_exp_reg;
        small_exp  = g_big ? q_exp_reg : g_reg[62:52];
        big_frac   = g_big ? g_reg[51:0] : q_frac_reg;
        small_frac = g_big ? q_frac_reg : g_reg[51:0];
        a_diff     = big_exp - small_exp;
        a_sh       = (a_diff > 11'd56) ? 6'd56 : a_diff[5:0];
        small_ext  = {1'b1, small_frac, 3'b000};
        small_shf  = small_ext >> a_sh;
        a_stk      = (small_shf << a_sh) != small_ext;
        a_sum      = {1'b0, 1'b1, big_frac, 3'b000} + {1'b0, small_shf | 56'(a_stk)};
        if (a_sum[56])
        begin
            a_norm = {a_sum[56:2], a_sum[1] | a_sum[0]};
            a_exp  = {1'b0, big_exp} + 12'd1;
        end
        else
        begin
            a_norm = a_sum[55:0];
            a_exp  = {1'b0, big_exp};
        end
        a_grd = a_norm[2];
        a_inc = a_grd & ((|a_norm[1:0]) | a_norm[3]);
        a_rnd = {1'b0, a_norm[55:3]} + 54'(a_inc);
        if (a_rnd[53])
        begin
            ng_frac = a_rnd[52:1];
            ng_exp  = a_exp + 12'd1 - 12'd1;
        end
        else
        begin
            ng_frac = a_rnd[51:0];
            ng_exp  = a_exp - 12'd1;
        end
        ng_bits = {1'b0, ng_exp[10:0], ng_frac};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (in_exp_zero)
            begin
                x_man_reg <= {1'b0, operand_bits[51:0]};
                x_exp_reg <= 13'sd1;
            end
            else
            begin
                x_man_reg <= {1'b1, operand_bits[51:0]};
                x_exp_reg <= $signed({2'b00, operand_bits[62:52]});
            end
            g_reg <= in_special ? in_special_val
                                : ({1'b0, operand_bits[63:1]} + fsqn_pkg::SEED_BIAS);
        end
        if (cmd.norm_step)
        begin
            x_man_reg <= {x_man_reg[51:0], 1'b0};
            x_exp_reg <= x_exp_reg - 13'sd1;
        end
        if (cmd.div_init)
        begin
            rem_reg <= {1'b0, x_man_reg};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_diff[52:0], 1'b0};
            quo_reg <= {quo_reg[54:0], rem_ge};
        end
        if (cmd.q_round)
        begin
            q_frac_reg <= q_frac_next;
            q_exp_reg  <= q_exp_next;
        end
        if (cmd.add_step)
            g_reg <= ng_bits;
    end

    always_comb
    begin
        sts.special   = in_special;
        sts.norm_done = x_man_reg[52];
        sts.same      = ng_bits == g_reg;
        root_bits     = g_reg;
    end

endmodule

// File: rtl/fp64_sqrt_newton.sv
// Top level of the binary64 Newton-Raphson square root block.
// One request at a time: zeros, NaNs, +inf and negatives go from the load
// straight to the result. Other operands pass through the load, then
// normalization, which shifts a subnormal fraction left until its leading
// bit is set, then per Newton step the divider steps, quotient rounding and
// an add, for at most 5 steps, then the result. Most of the time goes to
// the radix-2 restoring divider.
module fp64_sqrt_newton (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] root_bits
);

    fsqn_pkg::cmd_t cmd;
    fsqn_pkg::sts_t sts;

    fsqn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fsqn_dp u_dp (
        .clk          (clk),
        .operand_bits (operand_bits),
        .cmd          (cmd),
        .sts          (sts),
        .root_bits    (root_bits)
    );

endmodule
